### rtl/rci_pkg.sv
// Shared constants for the ray/cylinder intersection pipeline.
// No dependencies; imported by ray_cylinder_intersect.
`default_nettype none

package rci_pkg;

  // Limits of the 64-bit signed working format.
  localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64_MIN = {1'b1, {63{1'b0}}};

  // Surface codes reported with a hit.
  localparam logic [1:0] PART_SIDE   = 2'd0;
  localparam logic [1:0] PART_TOP    = 2'd1;
  localparam logic [1:0] PART_BOTTOM = 2'd2;

  // Configuration register indexes.
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

`default_nettype wire

### rtl/ray_cylinder_intersect.sv
// Ray against capped z-axis cylinder, fixed point, fully pipelined.
// Depends on rci_pkg for format limits, surface codes and register indexes.
//
// Usage: one ray per transaction on the input channel (in_valid_i/in_ready_o),
// one result per ray on the output channel (out_valid_o/out_ready_i), in order.
// Radius and height are written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// pipeline is empty; reset sets both to 1.0.
// Stages, in order: input stages, SQS square-root stages (four root bits each),
// stage N, DVS divider stages (eight quotient bits each), stages T, Z1, output.
// Throughput: one ray per cycle while the receiver does not stall. The square
// root and the side-distance division are unrolled over register stages, so no
// unit is shared between rays. Each stage holds its own valid bit and advances
// whenever the stage after it is empty or moving, so a stalled receiver only
// holds the output register and the items behind it close up into free stages;
// in_ready_o drops only once every stage is full. Reset empties the pipeline;
// payload registers are not cleared.
`default_nettype none

module ray_cylinder_intersect #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [COORD_WIDTH-2:0]           cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]    origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]    origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]    origin_z_i,
  input  logic signed [FRACTION_BITS+1:0]  dir_x_i,
  input  logic signed [FRACTION_BITS+1:0]  dir_y_i,
  input  logic signed [FRACTION_BITS+1:0]  dir_z_i,
  input  logic signed [COORD_WIDTH-1:0]    inv_dir_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic signed [COORD_WIDTH-1:0]    hit_distance_o,
  output logic [1:0]                       hit_part_o
);
  import rci_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int DW   = F + 2;
  localparam int RW   = CW - 1;
  localparam int K2W  = F + 3;
  localparam int K1W  = CW + 3;
  localparam int K0A  = 2 * CW - F + 2;
  localparam int K0W  = (K0A < 64) ? K0A : 64;
  localparam int TCA  = 2 * CW - F + 1;
  localparam int TCW  = (TCA < 64) ? TCA : 64;
  localparam int PXD  = CW + DW;
  localparam int PXX  = 2 * CW;
  localparam int PRR  = 2 * RW;
  localparam int PTC  = 2 * CW + 1;
  localparam int P11  = 2 * K1W;
  localparam int P20  = K2W + K0W;
  localparam int P2T  = K2W + TCW;
  localparam int SQW  = (64 + F) / 2;
  localparam int BPS  = 4;
  localparam int SQS  = (SQW + BPS - 1) / BPS;
  localparam int DVI  = 63;
  localparam int DPS  = 8;
  localparam int DVS  = (DVI + DPS - 1) / DPS;
  localparam int S_SQ = 4;
  localparam int S_N  = S_SQ + SQS;
  localparam int S_DV = S_N + 1;
  localparam int S_T  = S_DV + DVS;
  localparam int S_Z1 = S_T + 1;
  localparam int S_O  = S_T + 2;
  localparam int NS   = S_O + 1;

  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< F;
  localparam logic signed [63:0] OMAX  = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] OMIN  = -OMAX - 64'sd1;
  localparam logic [RW-1:0]      ONE_R = RW'(64'd1 << F);

  typedef struct packed {
    logic                  miss;
    logic signed [K1W-1:0] k1;
    logic signed [K2W-1:0] k2;
    logic signed [CW-1:0]  oz;
    logic signed [DW-1:0]  dz;
    logic signed [CW-1:0]  tb_o;
    logic signed [CW-1:0]  tt_o;
    logic [63:0]           cb_a;
    logic [63:0]           ct_a;
    logic                  hb;
    logic                  ht;
    logic                  neg;
    logic                  sat;
  } carry_t;

  // Drop the fraction bits of a product toward zero and saturate the magnitude.
  function automatic logic signed [63:0] qnorm(input logic signed [127:0] p);
    logic [127:0] mag;
    logic [127:0] shr;
    logic [63:0]  m64;
    mag = p[127] ? (~p + 128'd1) : p;
    shr = mag >> F;
    m64 = (shr > 128'(I64_MAX)) ? I64_MAX : shr[63:0];
    return p[127] ? -m64 : m64;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sabs(input logic signed [63:0] c);
    if (!c[63]) return c;
    return (c == I64_MIN) ? I64_MAX : -c;
  endfunction

  function automatic logic signed [CW-1:0] clampc(input logic signed [63:0] t);
    if (t > OMAX) return OMAX[CW-1:0];
    if (t < OMIN) return OMIN[CW-1:0];
    return t[CW-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [RW-1:0] radius_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= ONE_R;
      height_q <= ONE_R;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  // ------------------------------------------- stage 1: input products
  logic signed [2*DW-1:0] s1_zz_q;
  logic signed [PXD-1:0]  s1_xd_q, s1_yd_q;
  logic signed [PXX-1:0]  s1_xx_q, s1_yy_q;
  logic [PRR-1:0]         s1_rr_q;
  logic signed [PTC-1:0]  s1_tb_q, s1_tt_q;
  logic signed [CW-1:0]   s1_oz_q;
  logic signed [DW-1:0]   s1_dz_q;
  logic signed [CW:0]     nb, nt;

  // Cap plane offsets: bottom plane at zero, top plane at the height.
  assign nb = (CW+1)'(0) - (CW+1)'(origin_z_i);
  assign nt = $signed({2'b00, height_q}) - (CW+1)'(origin_z_i);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_zz_q <= (2*DW)'(dir_z_i) * (2*DW)'(dir_z_i);
      s1_xd_q <= PXD'(origin_x_i) * PXD'(dir_x_i);
      s1_yd_q <= PXD'(origin_y_i) * PXD'(dir_y_i);
      s1_xx_q <= PXX'(origin_x_i) * PXX'(origin_x_i);
      s1_yy_q <= PXX'(origin_y_i) * PXX'(origin_y_i);
      s1_rr_q <= PRR'(radius_q) * PRR'(radius_q);
      s1_tb_q <= PTC'(nb) * PTC'(inv_dir_z_i);
      s1_tt_q <= PTC'(nt) * PTC'(inv_dir_z_i);
      s1_oz_q <= origin_z_i;
      s1_dz_q <= dir_z_i;
    end
  end

  // -------------------------------------- stage 2: quadratic coefficients
  logic signed [K2W-1:0] s2_k2_q;
  logic signed [K1W-1:0] s2_k1_q;
  logic signed [K0W-1:0] s2_k0_q;
  logic signed [TCW-1:0] s2_tb_q, s2_tt_q;
  logic signed [CW-1:0]  s2_oz_q;
  logic signed [DW-1:0]  s2_dz_q;
  logic signed [63:0]    k2_w, k1_w, k0_w, tb_w, tt_w;

  always_comb begin
    k2_w = ONE_Q - qnorm(128'(s1_zz_q));
    k1_w = sadd(qnorm(128'(s1_xd_q)), qnorm(128'(s1_yd_q)));
    k0_w = ssub(sadd(qnorm(128'(s1_xx_q)), qnorm(128'(s1_yy_q))),
                qnorm($signed(128'(s1_rr_q))));
    tb_w = qnorm(128'(s1_tb_q));
    tt_w = qnorm(128'(s1_tt_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_k2_q <= K2W'(k2_w);
      s2_k1_q <= K1W'(k1_w);
      s2_k0_q <= K0W'(k0_w);
      s2_tb_q <= TCW'(tb_w);
      s2_tt_q <= TCW'(tt_w);
      s2_oz_q <= s1_oz_q;
      s2_dz_q <= s1_dz_q;
    end
  end

  // ------------------------------- stage 3: discriminant and cap products
  logic signed [P11-1:0] s3_11_q;
  logic signed [P20-1:0] s3_20_q;
  logic signed [P2T-1:0] s3_2b_q, s3_2t_q;
  logic signed [K2W-1:0] s3_k2_q;
  logic signed [K1W-1:0] s3_k1_q;
  logic signed [TCW-1:0] s3_tb_q, s3_tt_q;
  logic signed [CW-1:0]  s3_oz_q;
  logic signed [DW-1:0]  s3_dz_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_11_q <= P11'(s2_k1_q) * P11'(s2_k1_q);
      s3_20_q <= P20'(s2_k2_q) * P20'(s2_k0_q);
      s3_2b_q <= P2T'(s2_k2_q) * P2T'(s2_tb_q);
      s3_2t_q <= P2T'(s2_k2_q) * P2T'(s2_tt_q);
      s3_k2_q <= s2_k2_q;
      s3_k1_q <= s2_k1_q;
      s3_tb_q <= s2_tb_q;
      s3_tt_q <= s2_tt_q;
      s3_oz_q <= s2_oz_q;
      s3_dz_q <= s2_dz_q;
    end
  end

  // ---------------------------- stage 4: discriminant, cap radial terms
  logic signed [63:0] h_w, h_q;
  carry_t             s4_d, s4_q;

  always_comb begin
    h_w        = ssub(qnorm(128'(s3_11_q)), qnorm(128'(s3_20_q)));
    s4_d       = '0;
    // A negative discriminant, or a direction with no radial part, misses.
    s4_d.miss  = h_w[63] || s3_k2_q[K2W-1] || (s3_k2_q == '0);
    s4_d.k1    = s3_k1_q;
    s4_d.k2    = s3_k2_q;
    s4_d.oz    = s3_oz_q;
    s4_d.dz    = s3_dz_q;
    s4_d.tb_o  = clampc(64'(s3_tb_q));
    s4_d.tt_o  = clampc(64'(s3_tt_q));
    s4_d.cb_a  = sabs(sadd(64'(s3_k1_q), qnorm(128'(s3_2b_q))));
    s4_d.ct_a  = sabs(sadd(64'(s3_k1_q), qnorm(128'(s3_2t_q))));
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      h_q  <= h_w;
      s4_q <= s4_d;
    end
  end

  // ---------------------------- square root, four root bits per stage
  logic [SQW+1:0]   sq_rem_q  [SQS];
  logic [SQW-1:0]   sq_root_q [SQS];
  logic [2*SQW-1:0] sq_rad_q  [SQS];
  carry_t           sq_c_q    [SQS];

  for (genvar st = 0; st < SQS; st++) begin : g_sq
    logic [SQW+1:0]   rem_in, rem_d;
    logic [SQW-1:0]   root_in, root_d;
    logic [2*SQW-1:0] rad_in, rad_d;
    carry_t           c_in;

    if (st == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = (2*SQW)'({h_q[62:0], {F{1'b0}}});
      assign c_in    = s4_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[st-1];
      assign root_in = sq_root_q[st-1];
      assign rad_in  = sq_rad_q[st-1];
      assign c_in    = sq_c_q[st-1];
    end

    always_comb begin
      logic [SQW+1:0] cur;
      logic [SQW+1:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      rad_d  = rad_in;
      for (int j = 0; j < BPS; j++) begin
        if (st * BPS + j < SQW) begin
          cur   = {rem_d[SQW-1:0], rad_d[2*SQW-1 -: 2]};
          trial = {root_d, 2'b01};
          rad_d = rad_d << 2;
          if (cur >= trial) begin
            rem_d  = cur - trial;
            root_d = {root_d[SQW-2:0], 1'b1};
          end else begin
            rem_d  = cur;
            root_d = {root_d[SQW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S_SQ+st]) begin
        sq_rem_q[st]  <= rem_d;
        sq_root_q[st] <= root_d;
        sq_rad_q[st]  <= rad_d;
        sq_c_q[st]    <= c_in;
      end
    end
  end

  // ----------------- stage N: cap tests, side numerator, divider setup
  logic [SQW-1:0]     s_root;
  logic signed [63:0] num;
  logic [63:0]        num_m;
  logic [63+F:0]      num_w;
  logic [F:0]         den;
  carry_t             n_d, n_q;
  logic [F:0]         n_rem_q;
  logic [62:0]        n_sh_q;

  always_comb begin
    s_root = sq_root_q[SQS-1];
    n_d    = sq_c_q[SQS-1];
    n_d.hb = n_d.cb_a < 64'(s_root);
    n_d.ht = n_d.ct_a < 64'(s_root);
    num    = ssub(ssub(64'sd0, 64'(n_d.k1)), $signed(64'(s_root)));
    num_m  = num[63] ? (~num + 64'd1) : num;
    num_w  = {num_m, {F{1'b0}}};
    den    = n_d.k2[F:0];
    n_d.neg = num[63];
    // The quotient overflows exactly when its integer part reaches 2^(63-F).
    n_d.sat = num_w[63+F:63] >= den;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_N]) begin
      n_q     <= n_d;
      n_rem_q <= num_w[63+F:63];
      n_sh_q  <= num_w[62:0];
    end
  end

  // ----------------------- restoring divider, eight quotient bits per stage
  logic [F:0]  dv_rem_q [DVS];
  logic [62:0] dv_sh_q  [DVS];
  carry_t      dv_c_q   [DVS];

  for (genvar st = 0; st < DVS; st++) begin : g_dv
    logic [F:0]  rem_in, rem_d;
    logic [62:0] sh_in, sh_d;
    carry_t      c_in;

    if (st == 0) begin : g_first
      assign rem_in = n_rem_q;
      assign sh_in  = n_sh_q;
      assign c_in   = n_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[st-1];
      assign sh_in  = dv_sh_q[st-1];
      assign c_in   = dv_c_q[st-1];
    end

    always_comb begin
      logic [F+1:0] cur;
      logic [F+1:0] diff;
      logic [F+1:0] dv;
      dv    = (F+2)'(c_in.k2[F:0]);
      rem_d = rem_in;
      sh_d  = sh_in;
      for (int j = 0; j < DPS; j++) begin
        if (st * DPS + j < DVI) begin
          cur  = {rem_d, sh_d[62]};
          diff = cur - dv;
          sh_d = sh_d << 1;
          if (cur >= dv) begin
            rem_d   = diff[F:0];
            sh_d[0] = 1'b1;
          end else begin
            rem_d   = cur[F:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[S_DV+st]) begin
        dv_rem_q[st] <= rem_d;
        dv_sh_q[st]  <= sh_d;
        dv_c_q[st]   <= c_in;
      end
    end
  end

  // --------------------------- stage T: side distance and t*dz partials
  logic [62:0]        quo;
  logic signed [63:0] t_side;
  logic [DW-1:0]      adz;
  logic [31+DW:0]     t_plo_q;
  logic [30+DW:0]     t_phi_q;
  logic               t_sgn_q;
  logic signed [CW-1:0] t_dist_q;
  carry_t             t_c_q;

  always_comb begin
    quo    = dv_c_q[DVS-1].sat ? {63{1'b1}} : dv_sh_q[DVS-1];
    t_side = dv_c_q[DVS-1].neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    adz    = dv_c_q[DVS-1].dz[DW-1] ? -dv_c_q[DVS-1].dz : dv_c_q[DVS-1].dz;
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_T]) begin
      t_plo_q  <= (32+DW)'(quo[31:0]) * (32+DW)'(adz);
      t_phi_q  <= (31+DW)'(quo[62:32]) * (31+DW)'(adz);
      t_sgn_q  <= (dv_c_q[DVS-1].neg && (quo != '0)) ^ dv_c_q[DVS-1].dz[DW-1];
      t_dist_q <= clampc(t_side);
      t_c_q    <= dv_c_q[DVS-1];
    end
  end

  // ------------------------------------------- stage Z1: t*dz in Q format
  logic [62+DW:0]       pz_full, pz_shr;
  logic [63:0]          pz_mag;
  logic signed [63:0]   z1_tdz_q;
  logic signed [CW-1:0] z1_dist_q;
  carry_t               z1_c_q;

  always_comb begin
    pz_full = (63+DW)'({t_phi_q, 32'b0}) + (63+DW)'(t_plo_q);
    pz_shr  = pz_full >> F;
    pz_mag  = (pz_shr > (63+DW)'(I64_MAX)) ? I64_MAX : pz_shr[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_Z1]) begin
      z1_tdz_q  <= t_sgn_q ? -pz_mag : pz_mag;
      z1_dist_q <= t_dist_q;
      z1_c_q    <= t_c_q;
    end
  end

  // ----------------------------------- output stage: pick side or a cap
  logic signed [63:0]   z_w, hgt_w;
  logic                 hit_d, hit_q;
  logic signed [CW-1:0] dist_d, dist_q;
  logic [1:0]           part_d, part_q;

  always_comb begin
    z_w    = sadd(64'(z1_c_q.oz), z1_tdz_q);
    hgt_w  = $signed(64'(height_q));
    hit_d  = 1'b0;
    dist_d = '0;
    part_d = PART_SIDE;
    if (!z1_c_q.miss) begin
      if (z_w > 64'sd0 && z_w < hgt_w) begin
        hit_d  = 1'b1;
        dist_d = z1_dist_q;
      end else if (z_w[63] || (z_w == 64'sd0)) begin
        // Side point at or below the base: the bottom cap plane decides.
        if (z1_c_q.hb) begin
          hit_d  = 1'b1;
          dist_d = z1_c_q.tb_o;
          part_d = PART_BOTTOM;
        end
      end else if (z1_c_q.ht) begin
        hit_d  = 1'b1;
        dist_d = z1_c_q.tt_o;
        part_d = PART_TOP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_O]) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
      part_q <= part_d;
    end
  end

  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;
  assign hit_part_o     = part_q;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for ray_cylinder_intersect: capped cylinder hits in Q16.16.
// Depends on rci_pkg and the ray_cylinder_intersect RTL; predicts each result in-line.
`default_nettype none

module tb;
  import rci_pkg::*;

  localparam int FB = 16;
  localparam longint unsigned RMASK31 = 64'h7FFF_FFFF;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
    logic [1:0]  part;
  } hit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_RADIUS;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0, inv_dir_z_i = '0;
  logic signed [17:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic signed [31:0] hit_distance_o;
  logic [1:0] hit_part_o;

  ray_cylinder_intersect u_top (.*);

  // Shadow copy of the radius and height registers.
  longint radius_q = 65536;
  longint height_q = 65536;
  hit_result_t expected_hits[$];
  int n_errors = 0;
  int n_results = 0;
  int n_rays = 0;
  int n_side = 0, n_caps = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("Timeout with %0d results still expected", expected_hits.size());
    $display("Test completed with failures");
    $finish;
  end

  // Saturating Q16.16 arithmetic in 64-bit working precision.
  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return I64_MAX;
    if (a < 0 && b < 0 && s >= 0) return I64_MIN;
    return s;
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    longint s;
    s = a - b;
    if (a >= 0 && b < 0 && s < 0) return I64_MAX;
    if (a < 0 && b > 0 && s >= 0) return I64_MIN;
    return s;
  endfunction

  function automatic longint unsigned mag(longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] q;
    logic [63:0] m;
    p = 128'(mag(a)) * 128'(mag(b));
    q = p >> FB;
    m = (q > 128'(I64_MAX)) ? 64'(I64_MAX) : q[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_sqrt(longint h);
    logic [127:0] v;
    logic [127:0] root;
    logic [127:0] bitv;
    v = 128'(h) << FB;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      bitv = root | (128'(1) << i);
      if (bitv * bitv <= v) root = bitv;
    end
    return longint'(root[63:0]);
  endfunction

  function automatic longint q_div(longint num, longint den);
    logic [63:0] m, q, r, f;
    m = mag(num);
    q = m / 64'(den);
    r = m % 64'(den);
    f = (r << FB) / 64'(den);
    if (q > (64'(I64_MAX) >> FB)) q = 64'(I64_MAX);
    else q = (q << FB) + f;
    if (q > 64'(I64_MAX)) q = 64'(I64_MAX);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp_dist(longint t);
    if (t > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (t < -64'sh8000_0000) return 32'h8000_0000;
    return t[31:0];
  endfunction

  function automatic hit_result_t predict_hit(longint ox, longint oy, longint oz,
                                              longint dx, longint dy, longint dz,
                                              longint idz);
    hit_result_t res;
    longint k2, k1, k0, h, s, t, z, plane, c;
    logic [1:0] part;
    res = '0;
    k2 = 65536 - q_mul(dz, dz);
    k1 = sat_add(q_mul(ox, dx), q_mul(oy, dy));
    k0 = sat_sub(sat_add(q_mul(ox, ox), q_mul(oy, oy)), q_mul(radius_q, radius_q));
    h = sat_sub(q_mul(k1, k1), q_mul(k2, k0));
    if (h < 0 || k2 <= 0) return res;
    s = q_sqrt(h);
    t = q_div(sat_sub(sat_sub(0, k1), s), k2);
    z = sat_add(oz, q_mul(t, dz));
    if (z > 0 && z < height_q) begin
      res.hit = 1'b1;
      res.distance = clamp_dist(t);
      res.part = PART_SIDE;
      return res;
    end
    plane = (z <= 0) ? 0 : height_q;
    part = (z <= 0) ? PART_BOTTOM : PART_TOP;
    t = q_mul(sat_sub(plane, oz), idz);
    c = sat_add(k1, q_mul(k2, t));
    if (c < 0) c = (c == I64_MIN) ? I64_MAX : -c;
    if (c < s) begin
      res.hit = 1'b1;
      res.distance = clamp_dist(t);
      res.part = part;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, want);
  endtask

  // Receiver: random stalls, and each transaction checked against the oldest expectation.
  always @(posedge clk_i) begin
    hit_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_hits.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (hit_distance_o !== want.distance) begin
          report_mismatch("distance", hit_distance_o, want.distance);
        end
        if (hit_part_o !== want.part) report_mismatch("part", hit_part_o, want.part);
        if (want.hit) begin
          if (want.part == PART_SIDE) n_side++;
          else n_caps++;
        end
      end
      n_results++;
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid stays high from one transaction to the next unless the sender idles.
  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [17:0] dx, logic [17:0] dy, logic [17:0] dz,
                          logic [31:0] idz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ox;
    origin_y_i <= oy;
    origin_z_i <= oz;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    inv_dir_z_i <= idz;
    expected_hits.push_back(predict_hit($signed(ox), $signed(oy), $signed(oz),
                                        $signed(dx), $signed(dy), $signed(dz), $signed(idz)));
    n_rays++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, longint unsigned value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[30:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RADIUS) radius_q = value & RMASK31;
    else height_q = value & RMASK31;
  endtask

  // Random direction (x, y within +-0.707, z within +-1.0) with a matching reciprocal of z; sometimes raw noise.
  task automatic send_random_ray(int span);
    logic [17:0] dx, dy, dz;
    logic [31:0] idz;
    longint z;
    int scale;
    dx = 18'($signed($urandom_range(2 * 46341)) - 46341);
    dy = 18'($signed($urandom_range(2 * 46341)) - 46341);
    dz = 18'($signed($urandom_range(2 * 65536)) - 65536);
    z = $signed(dz);
    if (z == 0) idz = 32'h7FFF_FFFF;
    else if ((64'sd1 << 32) / z > 64'sh7FFF_FFFF) idz = 32'h7FFF_FFFF;
    else if ((64'sd1 << 32) / z < -64'sh8000_0000) idz = 32'h8000_0000;
    else idz = 32'((64'sd1 << 32) / z);
    scale = $urandom_range(3);
    if ($urandom_range(9) == 0) begin
      send_ray($urandom, $urandom, $urandom, 18'($urandom), 18'($urandom),
               18'($urandom), $urandom);
    end else begin
      send_ray(32'($signed($urandom_range(2 * span)) - span) <<< scale,
               32'($signed($urandom_range(2 * span)) - span) <<< scale,
               32'($signed($urandom_range(2 * span)) - span), dx, dy, dz, idz);
    end
  endtask

  task automatic test_directed();
    // Side hit from outside, both cap hits, axis-parallel, miss, field extremes.
    send_ray(-32'sd131072, 32'd0, 32'd32768, 18'd65536, 18'd0, 18'd0, 32'h7FFF_FFFF);
    send_ray(32'd0, 32'd0, 32'd196608, 18'd0, 18'd0, -18'sd65536, -32'sd65536);
    send_ray(32'd0, 32'd0, -32'sd131072, 18'd0, 18'd0, 18'd65536, 32'd65536);
    send_ray(32'd16384, 32'd0, -32'sd131072, 18'd0, 18'd0, 18'd65536, 32'd65536);
    send_ray(32'd0, 32'd0, 32'd0, 18'd46341, 18'd0, 18'd46341, 32'd92681);
    send_ray(32'd0, 32'd0, 32'd0, 18'd0, 18'd0, 18'd0, 32'h7FFF_FFFF);
    send_ray(32'd0, 32'd0, 32'd32768, 18'd65536, 18'd0, 18'd0, 32'h7FFF_FFFF);
    send_ray(32'd0, 32'd0, 32'd32768, -18'sd65536, 18'd0, 18'd0, 32'h7FFF_FFFF);
    send_ray(32'd0, 32'd262144, 32'd32768, 18'd0, 18'd65536, 18'd0, 32'h7FFF_FFFF);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'h1FFFF, 18'h1FFFF,
             18'h1FFFF, 32'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 18'h20000, 18'h20000,
             18'h20000, 32'h8000_0000);
    send_ray(32'hFFFF_FFFF, 32'h0, 32'h1, 18'h3FFFF, 18'h0, 18'h1, 32'hFFFF_FFFF);
    send_ray(32'd0, 32'd0, 32'd0, 18'd0, 18'd0, 18'd65536, 32'd65536);
    send_ray(32'd0, 32'd0, 32'd65536, 18'd0, 18'd0, -18'sd65536, -32'sd65536);
    send_ray(-32'sd200000, 32'd0, 32'd0, 18'd60000, 18'd0, 18'd26000, 32'd165000);
  endtask

  task automatic test_random_phase(int idle, int stall, int count, int span);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_random_ray(span);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_RADIUS, 1);
    write_reg(REG_HEIGHT, 1);
    test_random_phase(0, 0, 20, 2000);
    write_reg(REG_RADIUS, 64'h7FFF_FFFF);
    write_reg(REG_HEIGHT, 64'h7FFF_FFFF);
    test_random_phase(38, 38, 20, 1 << 30);
    write_reg(REG_RADIUS, 65536 * 3);
    write_reg(REG_HEIGHT, 65536 * 5);
    test_random_phase(0, 0, 60, 65536 * 8);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 150, 65536 * 3);
    test_random_phase(69, 0, 100, 65536 * 3);
    // Pause the sender until the pipeline has fully drained.
    wait_drained();
    test_random_phase(0, 69, 100, 65536 * 3);
    test_random_phase(38, 38, 100, 65536 * 3);
    test_config_extremes();
    wait_drained();
    $display("Sent %0d rays over several radius/height settings and idle patterns;", n_rays);
    $display("%0d side hits and %0d cap hits were checked.", n_side, n_caps);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire
